FILE: rtl/core/ipbf_pkg.sv
// Shared types, codes and constants for the IPv4 blocklist filter and flow counter.
`default_nettype none

package ipbf_pkg;

	localparam int BLOCK_SLOTS_DEF = 16;
	localparam int FLOW_SLOTS_DEF  = 256;

	localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
	localparam logic [15:0] FRAG_MORE   = 16'h2000;
	localparam logic [15:0] FRAG_OFFSET = 16'h1FFF;
	localparam logic [7:0]  PROTO_GRE   = 8'd47;

	localparam logic [1:0] CMD_CLASSIFY  = 2'd0;
	localparam logic [1:0] CMD_BL_WRITE  = 2'd1;
	localparam logic [1:0] CMD_FLOW_READ = 2'd2;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_ISOLATE  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_EN = 4'd1;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] ether_type;
		logic [15:0] frag_field;
		logic [7:0]  ip_protocol;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] packet_length;
		logic [7:0]  slot_index;
		logic [31:0] entry_value;
	} item_t;

	typedef struct packed {
		logic        verdict;
		logic        counted;
		logic        table_full;
		logic        read_valid;
		logic [31:0] read_source;
		logic [31:0] read_dest;
		logic [31:0] read_bytes;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic bscan;
		logic fscan;
		logic blk_wr;
		logic rd_slot;
		logic upd_rd;
		logic upd_wr;
		logic flow_new;
		logic set_drop;
		logic set_counted;
		logic set_full;
		logic set_read;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] command;
		logic       isolate;
		logic       block_en;
		logic       parse_pass;
		logic       bscan_done;
		logic       blk_hit;
		logic       fscan_done;
		logic       flow_hit;
		logic       flow_free;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/ipv4_blocklist_filter_flow_counter_unit.sv
// Top level: IPv4 blocklist filter with per-flow byte accounting.
// Isolated or unparsed packets, blocklist writes, flow reads and unused commands skip scans;
//   classify scans the blocklist when blocking is on, then the whole flow table unless blocked,
//   and a flow hit adds a read and a write of the byte count. The flow table scan dominates.
// Throughput: one item at a time; start is taken when busy is low, the next cycle after done.
// The result beat lasts one cycle on done and cannot be stalled by the receiver.
// Reset clears config, blocklist and flow valid bits at once; no clearing pass.
`default_nettype none

module ipv4_blocklist_filter_flow_counter_unit #(
	parameter int BLOCK_SLOTS = ipbf_pkg::BLOCK_SLOTS_DEF,
	parameter int FLOW_SLOTS  = ipbf_pkg::FLOW_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  ipbf_pkg::item_t                  item,
	output logic                             done,
	output ipbf_pkg::result_t                result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ipbf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ipbf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ipbf_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	ipbf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ipbf_dp #(
		.BLOCK_SLOTS (BLOCK_SLOTS),
		.FLOW_SLOTS  (FLOW_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule

`default_nettype wire

FILE: rtl/core/ipbf_dp.sv
// Datapath: item and config registers, blocklist and flow tables, scan and update logic.
`default_nettype none

module ipbf_dp #(
	parameter int BLOCK_SLOTS = ipbf_pkg::BLOCK_SLOTS_DEF,
	parameter int FLOW_SLOTS  = ipbf_pkg::FLOW_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ipbf_pkg::item_t                  item,
	input  logic                             cfg_wr,
	input  logic [ipbf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ipbf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  ipbf_pkg::dp_cmd_t                cmd,
	output ipbf_pkg::dp_status_t             status,
	output ipbf_pkg::result_t                result
);
	import ipbf_pkg::*;

	localparam int BIDX_W = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
	localparam int BCNT_W = $clog2(BLOCK_SLOTS + 1);
	localparam int FIDX_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
	localparam int FCNT_W = $clog2(FLOW_SLOTS + 1);

	item_t   item_q;
	result_t res_q;
	logic    isolate_q;
	logic    block_en_q;

	logic [31:0] src_key;
	logic [31:0] dst_key;
	logic        parse_pass;

	// blocklist
	logic [31:0]            blk_mem [BLOCK_SLOTS];
	logic [BLOCK_SLOTS-1:0] blk_valid_q;
	logic [31:0]            blk_rd_s1;
	logic                   blk_ok_s1;
	logic                   bpend_s1;
	logic [BCNT_W-1:0]      bcnt_q;
	logic                   blk_hit_q;
	logic                   blk_in_range;
	logic                   blk_wr_en;
	logic                   bscan_rd;
	logic [BIDX_W-1:0]      blk_slot;

	// flow table
	logic [63:0]           key_mem   [FLOW_SLOTS];
	logic [31:0]           bytes_mem [FLOW_SLOTS];
	logic [FLOW_SLOTS-1:0] flow_valid_q;
	logic [63:0]           key_rd_s1;
	logic [31:0]           bytes_rd_s1;
	logic                  fok_s1;
	logic                  fpend_s1;
	logic [FIDX_W-1:0]     fidx_s1;
	logic [FCNT_W-1:0]     fcnt_q;
	logic                  hit_q;
	logic [FIDX_W-1:0]     hit_idx_q;
	logic                  free_q;
	logic [FIDX_W-1:0]     free_idx_q;
	logic                  rd_ok_s1;
	logic                  flow_in_range;
	logic                  fscan_rd;
	logic [FIDX_W-1:0]     flow_slot;
	logic [FIDX_W-1:0]     fscan_idx;
	logic                  key_rd_en;
	logic [FIDX_W-1:0]     key_rd_addr;
	logic                  bytes_rd_en;
	logic [FIDX_W-1:0]     bytes_rd_addr;
	logic                  bytes_wr_en;
	logic [FIDX_W-1:0]     bytes_wr_addr;
	logic [31:0]           bytes_wr_data;

	// GRE packets fold onto the zero address pair
	assign src_key = (item_q.ip_protocol == PROTO_GRE) ? 32'd0 : item_q.source_address;
	assign dst_key = (item_q.ip_protocol == PROTO_GRE) ? 32'd0 : item_q.dest_address;
	assign parse_pass = (item_q.ether_type == ETYPE_IPV4)
		&& ((item_q.frag_field & (FRAG_MORE | FRAG_OFFSET)) == 16'd0);

	assign blk_slot     = item_q.slot_index[BIDX_W-1:0];
	assign blk_in_range = {1'b0, item_q.slot_index} < 9'(BLOCK_SLOTS);
	assign blk_wr_en    = cmd.blk_wr && blk_in_range;
	assign bscan_rd     = cmd.bscan && (bcnt_q < BCNT_W'(BLOCK_SLOTS));

	assign flow_slot     = item_q.slot_index[FIDX_W-1:0];
	assign flow_in_range = {1'b0, item_q.slot_index} < 9'(FLOW_SLOTS);
	assign fscan_idx     = fcnt_q[FIDX_W-1:0];
	assign fscan_rd      = cmd.fscan && (fcnt_q < FCNT_W'(FLOW_SLOTS));

	assign key_rd_en   = fscan_rd || cmd.rd_slot;
	assign key_rd_addr = cmd.rd_slot ? flow_slot : fscan_idx;

	assign bytes_rd_en   = cmd.upd_rd || cmd.rd_slot;
	assign bytes_rd_addr = cmd.rd_slot ? flow_slot : hit_idx_q;
	assign bytes_wr_en   = cmd.upd_wr || cmd.flow_new;
	assign bytes_wr_addr = cmd.flow_new ? free_idx_q : hit_idx_q;
	assign bytes_wr_data = cmd.flow_new ? {16'd0, item_q.packet_length}
		: bytes_rd_s1 + {16'd0, item_q.packet_length};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk) begin
		if (blk_wr_en) begin
			blk_mem[blk_slot] <= item_q.entry_value;
		end
		if (bscan_rd) begin
			blk_rd_s1 <= blk_mem[bcnt_q[BIDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flow_new) begin
			key_mem[free_idx_q] <= {src_key, dst_key};
		end
		if (key_rd_en) begin
			key_rd_s1 <= key_mem[key_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (bytes_wr_en) begin
			bytes_mem[bytes_wr_addr] <= bytes_wr_data;
		end
		if (bytes_rd_en) begin
			bytes_rd_s1 <= bytes_mem[bytes_rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isolate_q    <= 1'b0;
			block_en_q   <= 1'b0;
			blk_valid_q  <= '0;
			blk_ok_s1    <= 1'b0;
			bpend_s1     <= 1'b0;
			bcnt_q       <= '0;
			blk_hit_q    <= 1'b0;
			flow_valid_q <= '0;
			fok_s1       <= 1'b0;
			fpend_s1     <= 1'b0;
			fidx_s1      <= '0;
			fcnt_q       <= '0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			free_q       <= 1'b0;
			free_idx_q   <= '0;
			rd_ok_s1     <= 1'b0;
			res_q        <= '0;
		end else begin
			if (cfg_wr && (cfg_index == CFG_ISOLATE)) begin
				isolate_q <= cfg_data[0];
			end
			if (cfg_wr && (cfg_index == CFG_BLOCK_EN)) begin
				block_en_q <= cfg_data[0];
			end

			if (blk_wr_en) begin
				blk_valid_q[blk_slot] <= 1'b1;
			end
			if (cmd.flow_new) begin
				flow_valid_q[free_idx_q] <= 1'b1;
			end

			bpend_s1 <= bscan_rd;
			if (bscan_rd) begin
				blk_ok_s1 <= blk_valid_q[bcnt_q[BIDX_W-1:0]];
			end
			fpend_s1 <= fscan_rd;
			if (fscan_rd) begin
				fok_s1  <= flow_valid_q[fscan_idx];
				fidx_s1 <= fscan_idx;
			end
			if (cmd.rd_slot) begin
				rd_ok_s1 <= flow_in_range && flow_valid_q[flow_slot];
			end

			if (cmd.load) begin
				bcnt_q    <= '0;
				blk_hit_q <= 1'b0;
				fcnt_q    <= '0;
				hit_q     <= 1'b0;
				free_q    <= 1'b0;
				res_q     <= '0;
			end else begin
				if (bscan_rd) begin
					bcnt_q <= bcnt_q + BCNT_W'(1);
				end
				if (bpend_s1 && blk_ok_s1 && (blk_rd_s1 != 32'd0)
					&& ((blk_rd_s1 == src_key) || (blk_rd_s1 == dst_key))) begin
					blk_hit_q <= 1'b1;
				end

				if (fscan_rd) begin
					fcnt_q <= fcnt_q + FCNT_W'(1);
				end
				// first matching flow wins; otherwise remember the lowest free slot
				if (fpend_s1) begin
					if (fok_s1) begin
						if (!hit_q && (key_rd_s1 == {src_key, dst_key})) begin
							hit_q     <= 1'b1;
							hit_idx_q <= fidx_s1;
						end
					end else if (!free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= fidx_s1;
					end
				end

				if (cmd.set_drop) begin
					res_q.verdict <= 1'b1;
				end
				if (cmd.set_counted) begin
					res_q.counted <= 1'b1;
				end
				if (cmd.set_full) begin
					res_q.table_full <= 1'b1;
				end
				if (cmd.set_read && rd_ok_s1) begin
					res_q.read_valid  <= 1'b1;
					res_q.read_source <= key_rd_s1[63:32];
					res_q.read_dest   <= key_rd_s1[31:0];
					res_q.read_bytes  <= bytes_rd_s1;
				end
			end
		end
	end

	always_comb begin
		status            = '0;
		status.command    = item_q.command;
		status.isolate    = isolate_q;
		status.block_en   = block_en_q;
		status.parse_pass = parse_pass;
		status.bscan_done = (bcnt_q == BCNT_W'(BLOCK_SLOTS)) && !bpend_s1;
		status.blk_hit    = blk_hit_q;
		status.fscan_done = (fcnt_q == FCNT_W'(FLOW_SLOTS)) && !fpend_s1;
		status.flow_hit   = hit_q;
		status.flow_free  = free_q;
	end

	assign result = res_q;

	a_count_xor_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_q.counted && res_q.table_full))
		else $error("counted and table_full both set");

	a_drop_not_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.verdict |-> !res_q.counted)
		else $error("dropped packet was counted");

	a_update_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_wr |-> hit_q)
		else $error("byte update without a matching flow");

	a_new_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flow_new |-> (free_q && !hit_q && !flow_valid_q[free_idx_q]))
		else $error("new flow written over an occupied slot");

endmodule

`default_nettype wire

FILE: rtl/core/ipbf_ctrl.sv
// Controller: sequences decode, blocklist scan, flow scan, update, flow read and result beat.
`default_nettype none

module ipbf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  ipbf_pkg::dp_status_t  status,
	output ipbf_pkg::dp_cmd_t     cmd,
	output logic                  busy,
	output logic                  done
);
	import ipbf_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_BSCAN  = 8'b0000_0100,
		S_FSCAN  = 8'b0000_1000,
		S_UPD_RD = 8'b0001_0000,
		S_UPD_WR = 8'b0010_0000,
		S_READ   = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (status.command)
					CMD_CLASSIFY: begin
						if (status.isolate) begin
							cmd.set_drop = 1'b1;
							state_d      = S_DONE;
						end else if (!status.parse_pass) begin
							state_d = S_DONE;
						end else if (status.block_en) begin
							state_d = S_BSCAN;
						end else begin
							state_d = S_FSCAN;
						end
					end
					CMD_BL_WRITE: begin
						cmd.blk_wr = 1'b1;
						state_d    = S_DONE;
					end
					CMD_FLOW_READ: begin
						cmd.rd_slot = 1'b1;
						state_d     = S_READ;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_BSCAN: begin
				cmd.bscan = 1'b1;
				if (status.bscan_done) begin
					if (status.blk_hit) begin
						cmd.set_drop = 1'b1;
						state_d      = S_DONE;
					end else begin
						state_d = S_FSCAN;
					end
				end
			end
			S_FSCAN: begin
				cmd.fscan = 1'b1;
				if (status.fscan_done) begin
					if (status.flow_hit) begin
						state_d = S_UPD_RD;
					end else if (status.flow_free) begin
						cmd.flow_new    = 1'b1;
						cmd.set_counted = 1'b1;
						state_d         = S_DONE;
					end else begin
						cmd.set_full = 1'b1;
						state_d      = S_DONE;
					end
				end
			end
			S_UPD_RD: begin
				cmd.upd_rd = 1'b1;
				state_d    = S_UPD_WR;
			end
			S_UPD_WR: begin
				cmd.upd_wr      = 1'b1;
				cmd.set_counted = 1'b1;
				state_d         = S_DONE;
			end
			S_READ: begin
				cmd.set_read = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_DECODE))
		else $error("accepted item not decoded");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("still busy after result beat");

	a_bscan_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BSCAN) |-> (status.block_en && !status.isolate))
		else $error("blocklist scan while blocking disabled");

endmodule

`default_nettype wire

FILE: sim/tb_ipv4_blocklist_filter_flow_counter_unit.sv
// Testbench for the IPv4 blocklist filter and flow byte counter, checked against its own model.
module tb_ipv4_blocklist_filter_flow_counter_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ipbf_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES = 300;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = '1;

	class flow_filter_scoreboard;
		bit isolate_on;
		bit block_on;
		bit [31:0] block_addr [BLOCK_SLOTS_DEF];
		bit flow_used [FLOW_SLOTS_DEF];
		bit [31:0] flow_src [FLOW_SLOTS_DEF];
		bit [31:0] flow_dst [FLOW_SLOTS_DEF];
		bit [31:0] flow_total [FLOW_SLOTS_DEF];
		int flows_in_use;
		int failures;
		result_t expected_results[$];

		function int pending();
			return expected_results.size();
		endfunction

		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			CFG_ISOLATE: isolate_on = data[0];
			CFG_BLOCK_EN: block_on = data[0];
			default: ;
			endcase
		endfunction

		function result_t classify_packet(item_t it);
			result_t r;
			bit [31:0] src;
			bit [31:0] dst;
			int hit;
			int free_slot;
			r = '0;
			src = it.source_address;
			dst = it.dest_address;
			hit = -1;
			free_slot = -1;
			if (isolate_on) begin
				r.verdict = 1'b1;
				return r;
			end
			if (it.ether_type != ETYPE_IPV4 || (it.frag_field & (FRAG_MORE | FRAG_OFFSET)) != '0)
				return r;
			// GRE traffic is keyed on the zero address pair
			if (it.ip_protocol == PROTO_GRE) begin
				src = '0;
				dst = '0;
			end
			if (block_on) begin
				foreach (block_addr[i]) begin
					if (block_addr[i] != '0 && (block_addr[i] == src || block_addr[i] == dst)) begin
						r.verdict = 1'b1;
						return r;
					end
				end
			end
			foreach (flow_used[i]) begin
				if (flow_used[i]) begin
					if (hit < 0 && flow_src[i] == src && flow_dst[i] == dst)
						hit = i;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (hit < 0 && free_slot >= 0) begin
				hit = free_slot;
				flow_used[hit] = 1'b1;
				flow_src[hit] = src;
				flow_dst[hit] = dst;
				flow_total[hit] = '0;
				flows_in_use++;
			end
			if (hit < 0) begin
				r.table_full = 1'b1;
				return r;
			end
			flow_total[hit] = flow_total[hit] + 32'(it.packet_length);
			r.counted = 1'b1;
			return r;
		endfunction

		function void note_accepted(item_t it);
			result_t r;
			r = '0;
			case (it.command)
			CMD_CLASSIFY: r = classify_packet(it);
			CMD_BL_WRITE: begin
				if (it.slot_index < BLOCK_SLOTS_DEF)
					block_addr[it.slot_index] = it.entry_value;
			end
			CMD_FLOW_READ: begin
				if (flow_used[it.slot_index]) begin
					r.read_valid = 1'b1;
					r.read_source = flow_src[it.slot_index];
					r.read_dest = flow_dst[it.slot_index];
					r.read_bytes = flow_total[it.slot_index];
				end
			end
			default: ;
			endcase
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				failures++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				$error("result beat with nothing outstanding: 0x%0h", got);
				failures++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("verdict", 32'(want.verdict), 32'(got.verdict));
			compare_field("counted", 32'(want.counted), 32'(got.counted));
			compare_field("table_full", 32'(want.table_full), 32'(got.table_full));
			compare_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
			compare_field("read_source", want.read_source, got.read_source);
			compare_field("read_dest", want.read_dest, got.read_dest);
			compare_field("read_bytes", want.read_bytes, got.read_bytes);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic done;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	flow_filter_scoreboard sb;
	logic [31:0] addr_pool [8];
	int burst_left;
	int idle_cycles;

	ipv4_blocklist_filter_flow_counter_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result(result);
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic item_t scrambled_item();
		item_t it;
		it.command = 2'($urandom);
		it.ether_type = 16'($urandom);
		it.frag_field = 16'($urandom);
		it.ip_protocol = 8'($urandom);
		it.source_address = $urandom;
		it.dest_address = $urandom;
		it.packet_length = 16'($urandom);
		it.slot_index = 8'($urandom);
		it.entry_value = $urandom;
		return it;
	endfunction

	function automatic item_t make_packet(logic [15:0] etype, logic [15:0] frag,
			logic [7:0] proto, logic [31:0] src, logic [31:0] dst, logic [15:0] len);
		item_t it;
		it = scrambled_item();
		it.command = CMD_CLASSIFY;
		it.ether_type = etype;
		it.frag_field = frag;
		it.ip_protocol = proto;
		it.source_address = src;
		it.dest_address = dst;
		it.packet_length = len;
		return it;
	endfunction

	function automatic item_t make_bl_write(logic [7:0] slot, logic [31:0] value);
		item_t it;
		it = scrambled_item();
		it.command = CMD_BL_WRITE;
		it.slot_index = slot;
		it.entry_value = value;
		return it;
	endfunction

	function automatic item_t make_flow_read(logic [7:0] slot);
		item_t it;
		it = scrambled_item();
		it.command = CMD_FLOW_READ;
		it.slot_index = slot;
		return it;
	endfunction

	function automatic logic [31:0] pick_addr();
		if ($urandom_range(0, 9) < 7)
			return addr_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic item_t make_random_item();
		item_t it;
		int roll;
		int frag_roll;
		logic [15:0] etype;
		logic [15:0] frag;
		logic [7:0] proto;
		logic [7:0] slot;
		logic [31:0] value;
		roll = $urandom_range(0, 99);
		if (roll < 65) begin
			etype = ($urandom_range(0, 99) < 85) ? ETYPE_IPV4 : 16'($urandom);
			frag_roll = $urandom_range(0, 9);
			if (frag_roll < 6)
				frag = '0;
			else if (frag_roll < 8)
				frag = {2'($urandom), 14'd0};
			else
				frag = 16'($urandom);
			proto = ($urandom_range(0, 6) == 0) ? PROTO_GRE : 8'($urandom);
			it = make_packet(etype, frag, proto, pick_addr(), pick_addr(), 16'($urandom));
		end else if (roll < 77) begin
			if ($urandom_range(0, 4) == 0)
				slot = 8'($urandom_range(BLOCK_SLOTS_DEF, 255));
			else
				slot = 8'($urandom_range(0, BLOCK_SLOTS_DEF - 1));
			roll = $urandom_range(0, 9);
			if (roll < 7)
				value = addr_pool[$urandom_range(0, 7)];
			else if (roll < 8)
				value = '0;
			else
				value = $urandom;
			it = make_bl_write(slot, value);
		end else if (roll < 95) begin
			// mostly aim at slots that hold a flow
			if (sb.flows_in_use == 0 || $urandom_range(0, 3) == 0)
				slot = 8'($urandom);
			else
				slot = 8'($urandom_range(0, sb.flows_in_use - 1));
			it = make_flow_read(slot);
		end else begin
			it = scrambled_item();
			it.command = CMD_UNUSED;
		end
		return it;
	endfunction

	task automatic push_item(item_t it);
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_accepted(it);
	endtask

	task automatic gap(int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1)
			@(negedge clk);
	endtask

	// hold off until every outstanding result has come back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (2)
			@(negedge clk);
	endtask

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if ($urandom_range(0, 5) == 0)
				drain();
			else
				gap($urandom_range(1, 300));
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 5);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.apply_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] addr_a;
		logic [31:0] addr_b;
		logic [31:0] addr_c;
		logic [31:0] addr_e;
		bit iso_plan [6];
		bit blk_plan [6];
		int seq;
		item_t odd_item;
		sb = new();
		iso_plan = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		blk_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
		addr_a = 32'h0A00_0001;
		addr_b = 32'hC0A8_0001;
		addr_c = 32'hFFFF_FFFF;
		addr_e = 32'h8000_0000;
		addr_pool = '{addr_a, addr_b, addr_c, 32'h0, addr_e, 32'h0000_0001, $urandom, $urandom};
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		burst_left = 0;
		idle_cycles = 0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: parsing corners, GRE keying, blocklist edges, isolation
		push_item(make_flow_read(8'd0));
		push_item(make_packet(ETYPE_IPV4, '0, 8'd0, addr_a, addr_b, 16'hFFFF));
		push_item(make_packet(ETYPE_IPV4, '0, 8'hFF, addr_a, addr_b, 16'h0000));
		push_item(make_packet(ETYPE_IPV4, FRAG_MORE, 8'd6, addr_a, addr_b, 16'd100));
		push_item(make_packet(ETYPE_IPV4, 16'h0001, 8'd6, addr_a, addr_b, 16'd100));
		push_item(make_packet(ETYPE_IPV4, FRAG_OFFSET, 8'd6, addr_a, addr_b, 16'd100));
		push_item(make_packet(ETYPE_IPV4, 16'hC000, 8'd17, addr_c, 32'h0, 16'd1));
		push_item(make_packet(16'h86DD, '0, 8'd6, addr_a, addr_b, 16'd40));
		push_item(make_packet(ETYPE_IPV4, '0, PROTO_GRE, addr_a, addr_b, 16'd7));
		push_item(make_random_item());
		odd_item = scrambled_item();
		odd_item.command = CMD_UNUSED;
		push_item(odd_item);
		push_item(make_flow_read(8'd1));
		push_item(make_flow_read(8'd2));
		push_item(make_flow_read(8'hFF));
		push_item(make_bl_write(8'd0, addr_a));
		push_item(make_bl_write(8'(BLOCK_SLOTS_DEF - 1), addr_c));
		push_item(make_bl_write(8'(BLOCK_SLOTS_DEF), addr_b));
		push_item(make_bl_write(8'hFF, addr_b));
		write_reg(CFG_BLOCK_EN, {31'($urandom), 1'b1});
		push_item(make_packet(ETYPE_IPV4, '0, 8'd6, addr_a, addr_b, 16'd10));
		push_item(make_packet(ETYPE_IPV4, '0, 8'd6, addr_e, addr_c, 16'd10));
		push_item(make_packet(ETYPE_IPV4, '0, 8'd6, addr_b, addr_e, 16'd10));
		push_item(make_packet(ETYPE_IPV4, '0, PROTO_GRE, addr_a, addr_c, 16'd3));
		push_item(make_bl_write(8'd0, 32'h0));
		push_item(make_packet(ETYPE_IPV4, '0, 8'd6, addr_a, addr_b, 16'd5));
		write_reg(CFG_ISOLATE, {31'($urandom), 1'b1});
		push_item(make_packet(ETYPE_IPV4, '0, 8'd6, addr_a, addr_b, 16'd5));
		push_item(make_packet(16'hFFFF, 16'hFFFF, 8'd6, addr_a, addr_b, 16'd5));
		push_item(make_flow_read(8'd0));
		write_reg(CFG_IDX_LAST, '1);
		write_reg(CFG_IDX_W'(CFG_BLOCK_EN + 1), '1);

		// random traffic over a spread of register settings
		for (int phase = 0; phase < 6; phase++) begin
			write_reg(CFG_ISOLATE, {31'($urandom), iso_plan[phase]});
			write_reg(CFG_BLOCK_EN, {31'($urandom), blk_plan[phase]});
			if ($urandom_range(0, 1) == 0)
				write_reg(CFG_IDX_W'($urandom_range(CFG_BLOCK_EN + 1, CFG_IDX_LAST)), $urandom);
			for (int n = 0; n < (iso_plan[phase] ? 20 : 60); n++) begin
				push_item(make_random_item());
				pace();
			end
		end

		// fill the flow table with fresh pairs, then overflow it
		write_reg(CFG_ISOLATE, '0);
		write_reg(CFG_BLOCK_EN, '0);
		seq = 0;
		while (sb.flows_in_use < FLOW_SLOTS_DEF) begin
			push_item(make_packet(ETYPE_IPV4, '0, 8'($urandom_range(0, PROTO_GRE - 1)),
				{8'hE5, 24'(seq)}, $urandom, 16'($urandom)));
			seq++;
			pace();
		end
		for (int n = 0; n < 12; n++) begin
			push_item(make_packet(ETYPE_IPV4, {2'($urandom), 14'd0}, 8'($urandom_range(48, 255)),
				{8'hE6, 24'(n)}, $urandom, 16'($urandom)));
			pace();
		end
		push_item(make_packet(ETYPE_IPV4, '0, PROTO_GRE, $urandom, $urandom, 16'hFFFF));
		push_item(make_packet(ETYPE_IPV4, '0, 8'd6, addr_a, addr_b, 16'hFFFF));
		write_reg(CFG_BLOCK_EN, {31'($urandom), 1'b1});
		for (int n = 0; n < 40; n++) begin
			push_item(make_random_item());
			pace();
		end

		drain();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: ipv4_blocklist_filter_flow_counter_unit.f
rtl/core/ipbf_pkg.sv
rtl/core/ipbf_dp.sv
rtl/core/ipbf_ctrl.sv
rtl/core/ipv4_blocklist_filter_flow_counter_unit.sv
sim/tb_ipv4_blocklist_filter_flow_counter_unit.sv
